// ===== hw/rtl/rrt_pkg.sv =====
package rrt_pkg;

  // Table operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ADJUST = 2'd2,
    OP_SETCTX = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_LAUNCH = 2'd1,
    CS_PASS   = 2'd2,
    CS_FINISH = 2'd3
  } ctl_state_t;

  // Command held by the controller and seen by every cell.
  typedef struct packed {
    op_t                op;
    logic [63:0]        key;
    logic [31:0]        handle;
    logic signed [15:0] device;
    logic signed [15:0] delta;
  } cmd_t;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic               live;
    logic               found;
    logic               free_hit;
    logic               removed;
    logic [31:0]        count;
    logic [31:0]        handle;
    logic signed [15:0] device;
  } tok_t;

endpackage

// ===== hw/rtl/rrt_cell.sv =====
module rrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rrt_pkg::cmd_t cmd,
  input  logic          commit,
  input  rrt_pkg::tok_t tok_in,
  output rrt_pkg::tok_t tok_out
);
  import rrt_pkg::*;

  logic               valid_r, valid_nxt;
  logic               cand_r, cand_nxt;
  logic [63:0]        key_r, key_nxt;
  logic [31:0]        count_r, count_nxt;
  logic [31:0]        handle_r, handle_nxt;
  logic signed [15:0] device_r, device_nxt;
  tok_t               tok_r, tok_nxt;

  logic        match;
  logic [31:0] count_sum;
  logic [31:0] count_new;
  logic [31:0] handle_new;

  // Key compare and the entry's value after the command.
  assign match      = valid_r && (key_r == cmd.key);
  assign count_sum  = count_r + {{16{cmd.delta[15]}}, cmd.delta};
  assign count_new  = (cmd.op == OP_ADJUST) ? count_sum : count_r;
  assign handle_new = (cmd.op == OP_SETCTX) ? cmd.handle : handle_r;

  // The token updates a matching entry as it passes; a commit fills the claimed free slot.
  always_comb begin
    valid_nxt  = valid_r;
    cand_nxt   = cand_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    handle_nxt = handle_r;
    device_nxt = device_r;
    tok_nxt    = tok_in;
    if (tok_in.live) begin
      cand_nxt         = (cmd.op == OP_INSERT) && !valid_r && !tok_in.free_hit;
      tok_nxt.free_hit = tok_in.free_hit | !valid_r;
      if (match) begin
        tok_nxt.found  = 1'b1;
        tok_nxt.count  = count_new;
        tok_nxt.handle = handle_new;
        tok_nxt.device = device_r;
        tok_nxt.removed = 1'b0;
        if (cmd.op != OP_INSERT) begin
          count_nxt  = count_new;
          handle_nxt = handle_new;
        end
        if ((cmd.op == OP_ADJUST) && (count_new == 32'd0)) begin
          valid_nxt       = 1'b0;
          tok_nxt.removed = 1'b1;
        end
      end
    end else if (commit && cand_r) begin
      valid_nxt  = 1'b1;
      key_nxt    = cmd.key;
      count_nxt  = 32'd0;
      handle_nxt = cmd.handle;
      device_nxt = cmd.device;
    end
  end

  // Control state and the outgoing token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Entry contents are meaningful only while the entry is valid.
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    count_r  <= count_nxt;
    handle_r <= handle_nxt;
    device_r <= device_nxt;
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/refcounted_region_table.sv =====
// Reference-counted region table: an associative store of TABLE_ENTRIES entries keyed
// by a 64-bit region id, each holding a count, a context handle and a device id.
// Commands: raise start with the in_ fields while busy is low; the command is taken
// at that edge and busy stays high until the result has been shown.
// Operations are insert, lookup, adjust count (entry freed when the count reaches
// zero) and set context handle.
// The entries sit in a row of cells. A token carrying the search state walks the
// row one cell per cycle, so the row length sets the timing. A new command is
// taken only once the result of the previous one has been shown.
// Each result is on the out_ ports for exactly one cycle, flagged by out_valid; the
// receiver cannot hold it off, so every result transfer completes in that cycle.
// A successful insert writes the lowest free entry in the cycle the result shows.
// Reset (rst_n low, synchronous) marks all entries free and returns to idle.
module refcounted_region_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [63:0]        in_region_id,
  input  logic [31:0]        in_context_handle,
  input  logic signed [15:0] in_device_id,
  input  logic signed [15:0] in_count_delta,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_ref_count,
  output logic [31:0]        out_handle_out,
  output logic signed [15:0] out_device_out,
  output logic               out_entry_removed
);
  import rrt_pkg::*;

  ctl_state_t         state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               commit_r, commit_nxt;
  status_t            status_r, status_nxt;
  logic [31:0]        count_r, count_nxt;
  logic [31:0]        handle_r, handle_nxt;
  logic signed [15:0] device_r, device_nxt;
  logic               removed_r, removed_nxt;

  tok_t chain [TABLE_ENTRIES+1];
  tok_t tail;
  logic commit;

  // A fresh token enters the first cell during the launch cycle.
  always_comb begin
    chain[0]      = '0;
    chain[0].live = (state_r == CS_LAUNCH);
  end

  assign commit = (state_r == CS_FINISH) && commit_r;

  // Row of entry cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .commit  (commit),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  // Sequencer: take a command, launch the token, resolve the result at the row's end.
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    commit_nxt  = commit_r;
    status_nxt  = status_r;
    count_nxt   = count_r;
    handle_nxt  = handle_r;
    device_nxt  = device_r;
    removed_nxt = removed_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          cmd_nxt.op     = op_t'(in_operation);
          cmd_nxt.key    = in_region_id;
          cmd_nxt.handle = in_context_handle;
          cmd_nxt.device = in_device_id;
          cmd_nxt.delta  = in_count_delta;
          state_nxt      = CS_LAUNCH;
        end
      end
      CS_LAUNCH: begin
        state_nxt = CS_PASS;
      end
      CS_PASS: begin
        if (tail.live) begin
          state_nxt   = CS_FINISH;
          commit_nxt  = 1'b0;
          status_nxt  = ST_OK;
          count_nxt   = 32'd0;
          handle_nxt  = 32'd0;
          device_nxt  = 16'sd0;
          removed_nxt = 1'b0;
          if (cmd_r.op == OP_INSERT) begin
            priority if (tail.found) begin
              status_nxt = ST_DUPLICATE;
              count_nxt  = tail.count;
              handle_nxt = tail.handle;
              device_nxt = tail.device;
            end else if (tail.free_hit) begin
              commit_nxt = 1'b1;
              handle_nxt = cmd_r.handle;
              device_nxt = cmd_r.device;
            end else begin
              status_nxt = ST_FULL;
            end
          end else if (tail.found) begin
            count_nxt   = tail.count;
            handle_nxt  = tail.handle;
            device_nxt  = tail.device;
            removed_nxt = tail.removed;
          end else begin
            status_nxt = ST_MISSING;
          end
        end
      end
      CS_FINISH: begin
        state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CS_IDLE;
      commit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      commit_r <= commit_nxt;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    status_r  <= status_nxt;
    count_r   <= count_nxt;
    handle_r  <= handle_nxt;
    device_r  <= device_nxt;
    removed_r <= removed_nxt;
  end

  assign busy              = (state_r != CS_IDLE);
  assign out_valid         = (state_r == CS_FINISH);
  assign out_status        = status_r;
  assign out_ref_count     = count_r;
  assign out_handle_out    = handle_r;
  assign out_device_out    = device_r;
  assign out_entry_removed = removed_r;

endmodule

// ===== sim/refcounted_region_table_tb.sv =====
module refcounted_region_table_tb;
  import rrt_pkg::*;

  localparam int SLOTS = 64;
  localparam int KEY_POOL_SIZE = 96;
  // Watchdog limit: eight times one full pass of the row plus the longest gap.
  localparam int STALL_LIMIT = 8 * (SLOTS + 3 + 16);
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t            status;
    logic [31:0]        count;
    logic [31:0]        handle;
    logic signed [15:0] device;
    logic               removed;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = OP_LOOKUP;
  logic [63:0]        in_region_id = '0;
  logic [31:0]        in_context_handle = '0;
  logic signed [15:0] in_device_id = '0;
  logic signed [15:0] in_count_delta = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [31:0]        out_ref_count;
  logic [31:0]        out_handle_out;
  logic signed [15:0] out_device_out;
  logic               out_entry_removed;

  // Shadow copy of the table, updated in command order.
  logic               shadow_valid [SLOTS];
  logic [63:0]        shadow_key [SLOTS];
  logic [31:0]        shadow_count [SLOTS];
  logic [31:0]        shadow_handle [SLOTS];
  logic signed [15:0] shadow_device [SLOTS];

  table_result_t pending_results [$];
  logic [63:0]   key_pool [KEY_POOL_SIZE];
  int            mismatch_count = 0;
  int            stall_cycles = 0;
  bit            gaps_enabled = 1'b1;

  refcounted_region_table #(
    .TABLE_ENTRIES(SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_region_id      (in_region_id),
    .in_context_handle (in_context_handle),
    .in_device_id      (in_device_id),
    .in_count_delta    (in_count_delta),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_ref_count     (out_ref_count),
    .out_handle_out    (out_handle_out),
    .out_device_out    (out_device_out),
    .out_entry_removed (out_entry_removed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Returns the slot holding the key, or -1 when no valid slot matches.
  function automatic int find_entry(input logic [63:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += shadow_valid[i];
    return n;
  endfunction

  // Applies one command to the shadow table and returns the result it should give.
  function automatic table_result_t apply_table_op(input op_t op, input logic [63:0] key,
                                                   input logic [31:0] handle,
                                                   input logic signed [15:0] device,
                                                   input logic signed [15:0] delta);
    table_result_t res;
    int            slot;
    res = '{status: ST_OK, count: '0, handle: '0, device: '0, removed: 1'b0};
    slot = find_entry(key);
    if (op == OP_INSERT) begin
      if (slot >= 0) begin
        res.status = ST_DUPLICATE;
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
          return res;
        end
        shadow_valid[slot] = 1'b1;
        shadow_key[slot] = key;
        shadow_count[slot] = '0;
        shadow_handle[slot] = handle;
        shadow_device[slot] = device;
      end
    end else if (slot < 0) begin
      res.status = ST_MISSING;
      return res;
    end else if (op == OP_ADJUST) begin
      shadow_count[slot] = shadow_count[slot] + {{16{delta[15]}}, delta};
      if (shadow_count[slot] == '0) begin
        shadow_valid[slot] = 1'b0;
        res.removed = 1'b1;
      end
    end else if (op == OP_SETCTX) begin
      shadow_handle[slot] = handle;
    end
    res.count = shadow_count[slot];
    res.handle = shadow_handle[slot];
    res.device = shadow_device[slot];
    return res;
  endfunction

  // Sends one command after an optional idle gap and records its expected result.
  // The gap is counted from the cycle the block is idle again.
  task automatic send_cmd(input op_t op, input logic [63:0] key, input logic [31:0] handle,
                          input logic signed [15:0] device, input logic signed [15:0] delta);
    int gap;
    gap = gaps_enabled ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_region_id <= key;
    in_context_handle <= handle;
    in_device_id <= device;
    in_count_delta <= delta;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_table_op(op, key, handle, device, delta));
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [15:0] rand_device();
    return ($urandom_range(0, 3) == 0) ? -16'sd1 : 16'($urandom_range(0, 32767));
  endfunction

  // Every operation, the field extremes, missing keys, duplicates and count wrap.
  task automatic test_basic_ops();
    logic [63:0] k_lo;
    logic [63:0] k_hi;
    k_lo = 64'd0;
    k_hi = '1;
    send_cmd(OP_LOOKUP, k_lo, '0, '0, '0);
    send_cmd(OP_INSERT, k_lo, 32'h0000_0000, -16'sd1, 16'sd0);
    send_cmd(OP_INSERT, k_hi, 32'hffff_ffff, 16'sd32767, -16'sd1);
    send_cmd(OP_INSERT, k_lo, 32'h1234_5678, 16'sd5, 16'sd0);
    send_cmd(OP_LOOKUP, k_lo, '0, '0, '0);
    send_cmd(OP_LOOKUP, k_hi, '1, '1, '1);
    send_cmd(OP_LOOKUP, 64'h8000_0000_0000_0001, '0, '0, '0);
    send_cmd(OP_ADJUST, 64'h0123_4567_89ab_cdef, '0, '0, 16'sd3);
    send_cmd(OP_SETCTX, 64'hfedc_ba98_7654_3210, 32'hdead_beef, '0, '0);
    send_cmd(OP_SETCTX, k_lo, 32'ha5a5_5a5a, '0, '0);
    // Climb to the top of the delta range, then wrap below zero and back.
    send_cmd(OP_ADJUST, k_lo, '0, '0, 16'sd32767);
    send_cmd(OP_ADJUST, k_lo, '0, '0, -16'sd32768);
    send_cmd(OP_ADJUST, k_lo, '0, '0, -16'sd5);
    send_cmd(OP_ADJUST, k_lo, '0, '0, 16'sd6);
    send_cmd(OP_LOOKUP, k_lo, '0, '0, '0);
    // A zero delta on a zero count still frees the entry.
    send_cmd(OP_ADJUST, k_hi, '0, '0, 16'sd0);
    send_cmd(OP_SETCTX, k_hi, 32'h5555_aaaa, '0, '0);
    send_cmd(OP_INSERT, k_lo, 32'h0f0f_f0f0, 16'sd1, '0);
    send_cmd(OP_INSERT, k_hi, 32'hf0f0_0f0f, 16'sd16384, '0);
    send_cmd(OP_ADJUST, k_hi, '0, '0, -16'sd1);
    send_cmd(OP_ADJUST, k_hi, '0, '0, 16'sd1);
    send_cmd(OP_LOOKUP, k_hi, '0, '0, '0);
  endtask

  // Fills every free slot, hits the full table, frees a slot and refills it, then frees every filled slot.
  task automatic test_table_full();
    logic [63:0] fill_keys [SLOTS];
    int          n_fill;
    drain_results();
    n_fill = SLOTS - occupied_slots();
    for (int i = 0; i < n_fill; i++) begin
      fill_keys[i] = {$urandom, $urandom};
      send_cmd(OP_INSERT, fill_keys[i], $urandom, rand_device(), 16'($urandom));
    end
    send_cmd(OP_INSERT, {$urandom, $urandom}, $urandom, rand_device(), '0);
    send_cmd(OP_INSERT, fill_keys[0], $urandom, rand_device(), '0);
    // Free one entry from the middle and see the next insert land there.
    send_cmd(OP_ADJUST, fill_keys[n_fill / 2], '0, '0, 16'sd0);
    send_cmd(OP_INSERT, fill_keys[n_fill / 2], $urandom, rand_device(), '0);
    send_cmd(OP_INSERT, {$urandom, $urandom}, $urandom, rand_device(), '0);
    for (int i = 0; i < n_fill; i++) begin
      send_cmd(OP_ADJUST, fill_keys[i], '0, '0, 16'sd0);
    end
  endtask

  // Mixed traffic on a shared key pool, with counts kept near zero so entries come and go.
  task automatic test_random_traffic(input int n_items);
    int                 pick;
    int                 slot;
    op_t                op;
    logic [63:0]        key;
    logic signed [15:0] delta;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
      if (n == n_items / 2) drain_results();
      pick = $urandom_range(0, 99);
      op = (pick < 30) ? OP_INSERT : (pick < 50) ? OP_LOOKUP : (pick < 82) ? OP_ADJUST :
           OP_SETCTX;
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] :
            {$urandom, $urandom};
      slot = find_entry(key);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        delta = 16'($signed($urandom_range(0, 6)) - 3);
      end else if (pick < 80 && slot >= 0 && shadow_count[slot] <= 32'd32768) begin
        delta = 16'(32'd0 - shadow_count[slot]);
      end else begin
        delta = 16'($urandom);
      end
      send_cmd(op, key, $urandom, rand_device(), delta);
    end
  endtask

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status=%0d count=%h", out_status, out_ref_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_ref_count !== want.count ||
            out_handle_out !== want.handle || out_device_out !== want.device ||
            out_entry_removed !== want.removed) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected st=%0d cnt=%h hdl=%h dev=%0d rm=%b,",
                     want.status, want.count, want.handle, want.device, want.removed,
                     " got st=%0d cnt=%h hdl=%h dev=%0d rm=%b",
                     out_status, out_ref_count, out_handle_out, out_device_out,
                     out_entry_removed);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_table_full();
    test_random_traffic(680);
    drain_results();
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_cell.sv
hw/rtl/refcounted_region_table.sv
sim/refcounted_region_table_tb.sv
